// File: rtl/mbps_pkg.sv
// shared types and constants for the masked byte pattern scanner
// no dependencies; imported by every module of the block
package mbps_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int PAT_BYTES   = 32;
    localparam int PAT_IDX_W   = 5;
    localparam int CFG_LEN_W   = 6;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int CW          = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_MASK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE    = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_region;
    } t_in_item;

    typedef struct packed {
        logic [31:0] match_count;
        logic [31:0] last_match_address;
    } t_out_item;

    // one window position as seen by the tally stage
    typedef struct packed {
        logic        hit;
        logic        last;
        logic [31:0] addr;
    } t_hit_item;

endpackage

// File: rtl/mbps_cell.sv
// one window cell: holds a byte, hands it to the next cell on each shift
// and compares it against its aligned pattern byte; uses mbps_pkg
module mbps_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pat_byte,
    input  logic       i_care,
    output logic [7:0] o_byte,
    output logic       o_hit
);
    import mbps_pkg::*;

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = !i_care || (r_byte == i_pat_byte);

endmodule

// File: rtl/mbps_tally.sv
// per-region match counter, last match address and result register
// uses mbps_pkg for the hit and result transaction types
module mbps_tally (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  mbps_pkg::t_hit_item i_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mbps_pkg::t_out_item o_out_data
);
    import mbps_pkg::*;

    logic [31:0] r_cnt;
    logic [31:0] r_addr;
    logic        r_ov;
    t_out_item   r_out;
    logic [31:0] n_cnt;
    logic [31:0] n_addr;

    always_comb begin
        n_cnt  = r_cnt;
        n_addr = r_addr;
        if (i_item.hit) begin
            if (r_cnt != 32'hFFFF_FFFF) begin
                n_cnt = r_cnt + 32'd1;
            end
            n_addr = i_item.addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_addr <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (i_fire) begin
                if (i_item.last) begin
                    r_ov   <= 1'b1;
                    r_cnt  <= '0;
                    r_addr <= '0;
                end else begin
                    r_cnt  <= n_cnt;
                    r_addr <= n_addr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_item.last) begin
            r_out.match_count        <= n_cnt;
            r_out.last_match_address <= n_addr;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

// File: rtl/masked_byte_pattern_scanner.sv
// top level of the masked byte pattern scanner: config registers, window
// cell chain, alignment of pattern bytes and the tally stage
// depends on mbps_pkg, mbps_cell and mbps_tally
//
// Usage
// - input channel i_in_valid / o_in_stall / i_in_data carries one region byte
//   per transaction in ascending address order; end_of_region marks the last
// - output channel o_out_valid / i_out_stall / o_out_data carries one result
//   per region: the saturating match count and the address of the last match
// - throughput is one byte per cycle unless o_in_stall is high; the byte
//   enters the cell chain at the accepting edge and the window is compared
//   in the following cycle; the result is registered in the tally stage
//   when the compare stage advances with the last byte of the region
// - config writes (i_cfg_we, i_cfg_index, i_cfg_wdata) land at the next edge
//   and the user must make them while no region is in flight; not enforced
// - while the receiver stalls, bytes of the next region keep flowing until a
//   second region end reaches the compare stage; only then is o_in_stall high
// - reset clears the region state and the result valid flag, sets the pattern
//   length to one and the other config registers to zero
module masked_byte_pattern_scanner (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  mbps_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output mbps_pkg::t_out_item                 o_out_data
);
    import mbps_pkg::*;

    logic [63:0]          r_pat_word [0:3];
    logic [31:0]          r_mask;
    logic [CFG_LEN_W-1:0] r_len;
    logic [31:0]          r_base;

    logic                 r_a_v;
    logic                 r_a_last;
    logic                 r_restart;
    logic [LEN_W-1:0]     r_fill;
    logic [31:0]          r_seen;

    logic                 w_in_acc;
    logic                 w_fire_b;
    logic [CW-1:0]        w_len;
    logic [255:0]         w_pat_flat;
    logic [7:0]           w_chain [0:MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_hits;
    t_hit_item            w_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_word[0] <= '0;
            r_pat_word[1] <= '0;
            r_pat_word[2] <= '0;
            r_pat_word[3] <= '0;
            r_mask        <= '0;
            r_len         <= CFG_LEN_W'(1);
            r_base        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PATTERN_WORD0:  r_pat_word[0] <= i_cfg_wdata;
                CFG_PATTERN_WORD1:  r_pat_word[1] <= i_cfg_wdata;
                CFG_PATTERN_WORD2:  r_pat_word[2] <= i_cfg_wdata;
                CFG_PATTERN_WORD3:  r_pat_word[3] <= i_cfg_wdata;
                CFG_COMPARE_MASK:   r_mask        <= i_cfg_wdata[31:0];
                CFG_PATTERN_LENGTH: r_len         <= i_cfg_wdata[CFG_LEN_W-1:0];
                CFG_REGION_BASE:    r_base        <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    assign w_pat_flat = {r_pat_word[3], r_pat_word[2], r_pat_word[1], r_pat_word[0]};

    // zero acts as one, anything beyond the window depth as the depth
    always_comb begin
        w_len = CW'(r_len);
        if (w_len == '0) begin
            w_len = CW'(1);
        end else if (w_len > CW'(MAX_PATTERN)) begin
            w_len = CW'(MAX_PATTERN);
        end
    end

    // handshake and compare-stage advance
    assign w_fire_b   = r_a_v && (!r_a_last || !o_out_valid || !i_out_stall);
    assign o_in_stall = r_a_v && !w_fire_b;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v     <= 1'b0;
            r_a_last  <= 1'b0;
            r_restart <= 1'b1;
            r_fill    <= '0;
            r_seen    <= '0;
        end else if (w_in_acc) begin
            r_a_v     <= 1'b1;
            r_a_last  <= i_in_data.end_of_region;
            r_restart <= i_in_data.end_of_region;
            if (r_restart) begin
                r_fill <= LEN_W'(1);
                r_seen <= 32'd1;
            end else begin
                if (r_fill != LEN_W'(MAX_PATTERN)) begin
                    r_fill <= r_fill + LEN_W'(1);
                end
                r_seen <= r_seen + 32'd1;
            end
        end else if (w_fire_b) begin
            r_a_v <= 1'b0;
        end
    end

    // cell chain: cell k holds the byte seen k transactions ago
    assign w_chain[0] = i_in_data.data_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        localparam logic [CW-1:0] KC = CW'(k);
        logic [CW-1:0] w_j;
        logic [7:0]    w_pb;
        logic          w_care;

        // cell k lines up with pattern byte len-1-k
        always_comb begin
            w_j    = w_len - CW'(1) - KC;
            w_pb   = '0;
            w_care = 1'b0;
            if (KC < w_len && w_j < CW'(PAT_BYTES)) begin
                w_pb   = w_pat_flat[{w_j[PAT_IDX_W-1:0], 3'b000} +: 8];
                w_care = (w_j == '0) || r_mask[w_j[PAT_IDX_W-1:0]];
            end
        end

        mbps_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (w_in_acc),
            .i_byte     (w_chain[k]),
            .i_pat_byte (w_pb),
            .i_care     (w_care),
            .o_byte     (w_chain[k+1]),
            .o_hit      (w_hits[k])
        );
    end

    assign w_item.hit  = r_a_v && (&w_hits) && (CW'(r_fill) >= w_len);
    assign w_item.last = r_a_last;
    assign w_item.addr = r_base + r_seen - 32'(w_len);

    mbps_tally u_tally (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire_b),
        .i_item      (w_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_result_from_region_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_fire_b && r_a_last))
        else $error("result raised without a region end");

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(MAX_PATTERN))
        else $error("window fill beyond depth");

    a_no_match_no_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.match_count == 32'd0)
            |-> (o_out_data.last_match_address == 32'd0))
        else $error("address reported without a match");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for masked_byte_pattern_scanner: directed table, then random regions
// carries its own scan predictor and random handshake gaps; depends on mbps_pkg and the rtl
module testbench;
    import mbps_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 360;
    localparam int RANDOM_REGIONS = 20;
    localparam int DIRECTED_ROWS  = 24;

    typedef struct packed {
        logic [255:0] pattern;
        logic [31:0]  mask;
        logic [5:0]   length;
        logic [31:0]  base;
    } t_scan_setup;

    typedef struct packed {
        logic [2:0] setup_sel;
        logic [7:0] data_byte;
        logic       end_of_region;
        logic       has_typed;
        t_out_item  typed;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;

    masked_byte_pattern_scanner uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // register copies as the scanner should hold them
    logic [255:0] pat_bytes   = '0;
    logic [31:0]  cmp_mask    = '0;
    logic [5:0]   pat_len_reg = 6'd1;
    logic [31:0]  base_addr   = '0;

    // per-region scan state
    logic [7:0]   recent_bytes [MAX_PATTERN];
    logic [31:0]  bytes_in_region = '0;
    logic [31:0]  hits_in_region  = '0;
    logic [31:0]  last_hit_addr   = '0;
    int           window_fill     = 0;

    t_out_item    pending_results [$];

    int  check_errors    = 0;
    int  results_checked = 0;
    int  bytes_sent      = 0;
    int  regions_sent    = 0;
    int  setups_loaded   = 0;
    int  quiet_cycles    = 0;
    int  rx_left         = 0;
    logic sender_burst   = 1'b0;

    t_scan_setup setups [5] = '{
        '{256'h0, 32'h0, 6'd1, 32'h0},
        '{{256{1'b1}}, 32'h0, 6'd0, 32'hFFFF_FFFF},
        '{{256{1'b1}}, 32'h0, 6'd63, 32'h0000_1000},
        '{256'hEFBE_ADDE, 32'hFFFF_FFFF, 6'd4, 32'h8000_0000},
        '{256'hEFBE_ADDE, 32'h0000_0005, 6'd4, 32'h0000_0100}
    };

    // reset values, zero-or-one byte patterns, wrapping base, over-long pattern, masked hits
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{3'd0, 8'h00, 1'b1, 1'b1, '{32'd1, 32'd0}},
        '{3'd0, 8'hFF, 1'b1, 1'b1, '{32'd0, 32'd0}},
        '{3'd0, 8'h5A, 1'b0, 1'b0, '0},
        '{3'd0, 8'h00, 1'b1, 1'b1, '{32'd1, 32'd1}},
        '{3'd1, 8'hFF, 1'b0, 1'b0, '0},
        '{3'd1, 8'h00, 1'b0, 1'b0, '0},
        '{3'd1, 8'hFF, 1'b1, 1'b1, '{32'd2, 32'd1}},
        '{3'd1, 8'h00, 1'b0, 1'b0, '0},
        '{3'd1, 8'hFF, 1'b1, 1'b1, '{32'd1, 32'd0}},
        '{3'd2, 8'hFF, 1'b0, 1'b0, '0},
        '{3'd2, 8'hFF, 1'b0, 1'b0, '0},
        '{3'd2, 8'hFF, 1'b1, 1'b1, '{32'd0, 32'd0}},
        '{3'd3, 8'hDE, 1'b0, 1'b0, '0},
        '{3'd3, 8'hAD, 1'b0, 1'b0, '0},
        '{3'd3, 8'hBE, 1'b0, 1'b0, '0},
        '{3'd3, 8'hEF, 1'b0, 1'b0, '0},
        '{3'd3, 8'hDE, 1'b0, 1'b0, '0},
        '{3'd3, 8'hAD, 1'b0, 1'b0, '0},
        '{3'd3, 8'hBE, 1'b0, 1'b0, '0},
        '{3'd3, 8'hEF, 1'b1, 1'b1, '{32'd2, 32'h8000_0004}},
        '{3'd4, 8'hDE, 1'b0, 1'b0, '0},
        '{3'd4, 8'h00, 1'b0, 1'b0, '0},
        '{3'd4, 8'hBE, 1'b0, 1'b0, '0},
        '{3'd4, 8'h77, 1'b1, 1'b0, '0}
    };

    function automatic int active_length();
        int l;
        l = pat_len_reg;
        if (l == 0) l = 1;
        if (l > MAX_PATTERN) l = MAX_PATTERN;
        return l;
    endfunction

    function automatic logic [7:0] pattern_at(input int j);
        if (j >= PAT_BYTES) return 8'h00;
        return pat_bytes[8*j +: 8];
    endfunction

    function automatic logic is_compared(input int j);
        if (j == 0) return 1'b1;
        if (j >= PAT_BYTES) return 1'b0;
        return cmp_mask[j];
    endfunction

    // shift one byte into the window and tally a hit; the result is valid on region end
    task automatic scan_byte(input t_in_item item, output logic done, output t_out_item res);
        int   n;
        int   j;
        logic hit;
        n = active_length();
        for (j = MAX_PATTERN - 1; j > 0; j--) recent_bytes[j] = recent_bytes[j-1];
        recent_bytes[0] = item.data_byte;
        if (window_fill < MAX_PATTERN) window_fill++;
        bytes_in_region = bytes_in_region + 32'd1;
        hit = (window_fill >= n);
        for (j = 0; j < n; j++)
            if (is_compared(j) && recent_bytes[n-1-j] != pattern_at(j)) hit = 1'b0;
        if (hit) begin
            if (hits_in_region != 32'hFFFF_FFFF) hits_in_region = hits_in_region + 32'd1;
            last_hit_addr = base_addr + bytes_in_region - 32'(n);
        end
        done = item.end_of_region;
        res.match_count        = hits_in_region;
        res.last_match_address = last_hit_addr;
        if (done) begin
            foreach (recent_bytes[k]) recent_bytes[k] = 8'h00;
            bytes_in_region = '0;
            hits_in_region  = '0;
            last_hit_addr   = '0;
            window_fill     = 0;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    // upper bits of the narrow registers carry junk that must be dropped
    task automatic program_setup(input t_scan_setup s);
        write_reg(CFG_PATTERN_WORD0, s.pattern[63:0]);
        write_reg(CFG_PATTERN_WORD1, s.pattern[127:64]);
        write_reg(CFG_PATTERN_WORD2, s.pattern[191:128]);
        write_reg(CFG_PATTERN_WORD3, s.pattern[255:192]);
        write_reg(CFG_COMPARE_MASK, {$urandom, s.mask});
        write_reg(CFG_PATTERN_LENGTH, {$urandom, 26'($urandom), s.length});
        write_reg(CFG_REGION_BASE, {$urandom, s.base});
        i_cfg_we    <= 1'b0;
        pat_bytes   = s.pattern;
        cmp_mask    = s.mask;
        pat_len_reg = s.length;
        base_addr   = s.base;
        setups_loaded++;
    endtask

    // hold off the sender until every result is out and the pipeline is empty
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_byte(input t_in_item item, input logic use_typed,
                             input t_out_item typed);
        logic      done;
        t_out_item res;
        int        gap;
        int        r;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        scan_byte(item, done, res);
        bytes_sent++;
        if (done) begin
            pending_results.push_back(use_typed ? typed : res);
            regions_sent++;
        end
        gap = 0;
        if (!sender_burst) begin
            r = $urandom_range(0, 19);
            if (r >= 18)      gap = $urandom_range(5, 30);
            else if (r >= 12) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic t_scan_setup random_setup();
        t_scan_setup s;
        for (int k = 0; k < 8; k++) s.pattern[32*k +: 32] = $urandom;
        case ($urandom_range(0, 9))
            7, 8:    s.length = 6'($urandom_range(9, 32));
            9: begin
                case ($urandom_range(0, 2))
                    0:       s.length = 6'd0;
                    1:       s.length = 6'd32;
                    default: s.length = 6'($urandom_range(33, 63));
                endcase
            end
            default: s.length = 6'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 3))
            0:       s.mask = 32'hFFFF_FFFF;
            1:       s.mask = 32'h0;
            default: s.mask = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0:       s.base = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
            1:       s.base = 32'h0;
            default: s.base = $urandom;
        endcase
        return s;
    endfunction

    // mostly embedded pattern copies with random wildcard bytes, mixed with near-miss noise
    task automatic send_random_region();
        logic [7:0] region_bytes [$];
        int         n;
        int         len;
        int         j;
        logic       noise_only;
        t_in_item   item;
        n = active_length();
        if ($urandom_range(0, 7) == 0) len = $urandom_range(1, n);
        else                           len = $urandom_range(n, n + 12);
        noise_only   = ($urandom_range(0, 5) == 0);
        sender_burst = ($urandom_range(0, 2) == 0);
        while (region_bytes.size() < len) begin
            if (!noise_only && $urandom_range(0, 2) == 0 && len - region_bytes.size() >= n) begin
                for (j = 0; j < n; j++)
                    region_bytes.push_back(is_compared(j) ? pattern_at(j) : 8'($urandom));
            end else if ($urandom_range(0, 1) == 1) begin
                region_bytes.push_back(pattern_at($urandom_range(0, n - 1)));
            end else begin
                region_bytes.push_back(8'($urandom));
            end
        end
        foreach (region_bytes[k]) begin
            item.data_byte     = region_bytes[k];
            item.end_of_region = (k == region_bytes.size() - 1);
            send_byte(item, 1'b0, '0);
        end
    endtask

    // receiver: short stalls, a few long ones, and long stretches with none
    always @(posedge i_clk) begin
        if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    i_out_stall <= 1'b1;
                    rx_left     <= $urandom_range(0, 2);
                end
                3: begin
                    i_out_stall <= 1'b1;
                    rx_left     <= $urandom_range(8, 40);
                end
                4: begin
                    i_out_stall <= 1'b0;
                    rx_left     <= $urandom_range(40, 150);
                end
                default: begin
                    i_out_stall <= 1'b0;
                    rx_left     <= $urandom_range(0, 5);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending: count %0d address %h",
                         $time, o_out_data.match_count, o_out_data.last_match_address);
                check_errors++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (o_out_data.match_count !== want.match_count) begin
                    $display("%0t: match_count expected %0d got %0d",
                             $time, want.match_count, o_out_data.match_count);
                    check_errors++;
                end
                if (o_out_data.last_match_address !== want.last_match_address) begin
                    $display("%0t: last_match_address expected %h got %h",
                             $time, want.last_match_address, o_out_data.last_match_address);
                    check_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int        cur_sel;
        int        start_bytes;
        int        start_regions;
        t_in_item  item;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_PATTERN_WORD0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        foreach (recent_bytes[k]) recent_bytes[k] = 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; the first rows run on the reset register values
        cur_sel = 0;
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].setup_sel != cur_sel) begin
                settle_block();
                cur_sel = directed_rows[r].setup_sel;
                program_setup(setups[cur_sel]);
            end
            sender_burst       = ($urandom_range(0, 2) == 0);
            item.data_byte     = directed_rows[r].data_byte;
            item.end_of_region = directed_rows[r].end_of_region;
            send_byte(item, directed_rows[r].has_typed, directed_rows[r].typed);
        end

        start_bytes   = bytes_sent;
        start_regions = regions_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES ||
               regions_sent - start_regions < RANDOM_REGIONS) begin
            settle_block();
            program_setup(random_setup());
            repeat ($urandom_range(1, 5)) send_random_region();
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            check_errors++;
        end
        $display("scanned %0d bytes in %0d regions under %0d register settings",
                 bytes_sent, regions_sent, setups_loaded);
        $display("%0d results compared, %0d mismatches", results_checked, check_errors);
        if (check_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
